// ===== rtl/nrmb_pkg.sv =====
// Shared types and constants for the nucleotide rate matrix builder.
// Used by every module under rtl/ except nrmb_checker; depends on nothing.
package nrmb_pkg;

  localparam int RATE_W  = 24;    // Q8.16 exchange rate
  localparam int FREQ_W  = 16;    // Q0.16 base frequency
  localparam int OFF_W   = 40;    // rate * freq, Q8.32
  localparam int E_W     = 42;    // row sum, Q10.32
  localparam int TP_W    = 58;    // row sum * freq
  localparam int TOT_W   = 60;    // frequency-weighted total, Q12.48
  localparam int NORM_W  = 64;
  localparam int M_W     = 32;    // normalised mantissa
  localparam int Q_W     = 33;    // floor(2^63 / m) needs 33 bits
  localparam int DIV_STEPS = 4;   // quotient bits per cycle
  localparam int DIV_ITERS = 9;   // 36 quotient bits, top three always zero
  localparam int QI_W    = DIV_STEPS * DIV_ITERS;
  localparam int DCNT_W  = 4;
  localparam int N_W     = 6;     // bit length of the total, 1..60
  localparam int HALF_W  = 21;    // split of a 42-bit entry for the multiplier
  localparam int PP_W    = HALF_W + Q_W;
  localparam int PROD_W  = E_W + Q_W;
  localparam int FULL_W  = PROD_W + 9;
  localparam int VAL_W   = 32;
  localparam int NENT    = 16;
  localparam int QDEPTH  = 2;

  localparam logic [RATE_W-1:0] ONE_Q16   = 24'h010000;
  localparam logic [Q_W-1:0]    DIV_REM0  = 33'h008000000;  // 2^63 >> 36
  localparam logic [VAL_W-1:0]  POS_LIMIT = 32'h7FFFFFFF;
  localparam logic [VAL_W-1:0]  NEG_LIMIT = 32'h80000000;

  typedef struct packed {
    logic [RATE_W-1:0] rate_ac;
    logic [RATE_W-1:0] rate_ag;
    logic [RATE_W-1:0] rate_at;
    logic [RATE_W-1:0] rate_cg;
    logic [RATE_W-1:0] rate_ct;
    logic [RATE_W-1:0] rate_gt;
    logic [FREQ_W-1:0] freq_a;
    logic [FREQ_W-1:0] freq_c;
    logic [FREQ_W-1:0] freq_g;
    logic [FREQ_W-1:0] freq_t;
  } in_item_t;

  // one matrix in flight: raw entries, reciprocal and shift
  typedef struct packed {
    logic [NENT-1:0][E_W-1:0] e;
    logic [Q_W-1:0]           recip;
    logic [N_W-1:0]           n;
    logic                     degen;
  } q_entry_t;

  typedef struct packed {
    logic           start;
    logic [M_W-1:0] m;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] q;
  } div_rsp_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_MUL,
    F_SUM,
    F_TMUL,
    F_TOT,
    F_NORM,
    F_DIVGO,
    F_DIV,
    F_PUSH
  } front_state_t;

endpackage

// ===== rtl/nrmb_recip.sv =====
// Iterative reciprocal unit: floor(2^63 / m) for a normalised 32-bit m.
// Four restoring steps a cycle. Depends on nrmb_pkg.
module nrmb_recip (
  input  logic               clk,
  input  logic               rst_n,
  input  nrmb_pkg::div_req_t req,
  output nrmb_pkg::div_rsp_t rsp
);

  logic [nrmb_pkg::Q_W-1:0]    rem_r, rem_nxt;
  logic [nrmb_pkg::QI_W-1:0]   q_r, q_nxt;
  logic [nrmb_pkg::M_W-1:0]    m_r;
  logic [nrmb_pkg::DCNT_W-1:0] cnt_r;
  logic                        busy_r, done_r;

  always_comb begin
    logic [nrmb_pkg::Q_W-1:0] r;
    logic [nrmb_pkg::Q_W-1:0] mm;
    r  = rem_r;
    mm = {1'b0, m_r};
    q_nxt = q_r;
    for (int s = 0; s < nrmb_pkg::DIV_STEPS; s++) begin
      r = {r[nrmb_pkg::Q_W-2:0], 1'b0};   // rem < m, so no bit is lost
      q_nxt = {q_nxt[nrmb_pkg::QI_W-2:0], 1'b0};
      if (r >= mm) begin
        r = r - mm;
        q_nxt[0] = 1'b1;
      end
    end
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= nrmb_pkg::DCNT_W'(nrmb_pkg::DIV_ITERS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == nrmb_pkg::DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= nrmb_pkg::DIV_REM0;
      q_r   <= '0;
      m_r   <= req.m;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r[nrmb_pkg::Q_W-1:0];

endmodule

// ===== rtl/nrmb_front.sv =====
// Front end: input word holding register, mode register, entry products,
// total rate, normalisation and reciprocal sequencing. Depends on nrmb_pkg, nrmb_recip.
module nrmb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  nrmb_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  nrmb_pkg::q_stat_t   q_stat,
  output logic                q_push,
  output nrmb_pkg::q_entry_t  q_data
);

  function automatic logic [nrmb_pkg::OFF_W-1:0] mul_rf(
    input logic [nrmb_pkg::RATE_W-1:0] a,
    input logic [nrmb_pkg::FREQ_W-1:0] b
  );
    logic [nrmb_pkg::OFF_W-1:0] aa, bb;
    aa = {{(nrmb_pkg::OFF_W-nrmb_pkg::RATE_W){1'b0}}, a};
    bb = {{(nrmb_pkg::OFF_W-nrmb_pkg::FREQ_W){1'b0}}, b};
    return aa * bb;
  endfunction

  function automatic logic [nrmb_pkg::TP_W-1:0] mul_ef(
    input logic [nrmb_pkg::E_W-1:0]    a,
    input logic [nrmb_pkg::FREQ_W-1:0] b
  );
    logic [nrmb_pkg::TP_W-1:0] aa, bb;
    aa = {{(nrmb_pkg::TP_W-nrmb_pkg::E_W){1'b0}}, a};
    bb = {{(nrmb_pkg::TP_W-nrmb_pkg::FREQ_W){1'b0}}, b};
    return aa * bb;
  endfunction

  function automatic logic [nrmb_pkg::E_W-1:0] ext_e(input logic [nrmb_pkg::OFF_W-1:0] a);
    return {{(nrmb_pkg::E_W-nrmb_pkg::OFF_W){1'b0}}, a};
  endfunction

  function automatic logic [nrmb_pkg::TOT_W-1:0] ext_t(input logic [nrmb_pkg::TP_W-1:0] a);
    return {{(nrmb_pkg::TOT_W-nrmb_pkg::TP_W){1'b0}}, a};
  endfunction

  nrmb_pkg::front_state_t state_r, state_nxt;

  nrmb_pkg::in_item_t hold_r;
  logic               hold_full_r;
  logic               mode_r;
  logic               take;
  logic               div_start;

  logic [5:0][nrmb_pkg::RATE_W-1:0]         rate_r;
  logic [3:0][nrmb_pkg::FREQ_W-1:0]         freq_r;
  logic [nrmb_pkg::NENT-1:0][nrmb_pkg::E_W-1:0] e_r;
  logic [3:0][nrmb_pkg::TP_W-1:0]           tp_r;
  logic [nrmb_pkg::NORM_W-1:0]              norm_r, norm_nxt;
  logic [nrmb_pkg::N_W-1:0]                 lz_r, lz_nxt;
  logic [1:0]                               nstep_r;
  logic                                     degen_r;
  logic [nrmb_pkg::TOT_W-1:0]               tot_sum;

  nrmb_pkg::div_req_t div_req;
  nrmb_pkg::div_rsp_t div_rsp;

  nrmb_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall = hold_full_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nrmb_pkg::F_IDLE:  if (hold_full_r) state_nxt = nrmb_pkg::F_MUL;
      nrmb_pkg::F_MUL:   state_nxt = nrmb_pkg::F_SUM;
      nrmb_pkg::F_SUM:   state_nxt = nrmb_pkg::F_TMUL;
      nrmb_pkg::F_TMUL:  state_nxt = nrmb_pkg::F_TOT;
      nrmb_pkg::F_TOT:   state_nxt = (tot_sum == '0) ? nrmb_pkg::F_PUSH : nrmb_pkg::F_NORM;
      nrmb_pkg::F_NORM:  if (nstep_r == 2'd2) state_nxt = nrmb_pkg::F_DIVGO;
      nrmb_pkg::F_DIVGO: state_nxt = nrmb_pkg::F_DIV;
      nrmb_pkg::F_DIV:   if (div_rsp.done) state_nxt = nrmb_pkg::F_PUSH;
      nrmb_pkg::F_PUSH: begin
        if (!q_stat.full) state_nxt = hold_full_r ? nrmb_pkg::F_MUL : nrmb_pkg::F_IDLE;
      end
      default:           state_nxt = nrmb_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    take      = 1'b0;
    q_push    = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      nrmb_pkg::F_IDLE:  take = hold_full_r;
      nrmb_pkg::F_DIVGO: div_start = 1'b1;
      nrmb_pkg::F_PUSH: begin
        q_push = !q_stat.full;
        take   = !q_stat.full && hold_full_r;
      end
      default: ;
    endcase
  end

  assign div_req.start = div_start;
  assign div_req.m     = norm_r[nrmb_pkg::NORM_W-1 -: nrmb_pkg::M_W];

  assign tot_sum = ext_t(tp_r[0]) + ext_t(tp_r[1]) + ext_t(tp_r[2]) + ext_t(tp_r[3]);

  // leading-zero search, two halvings a cycle: 32/16, 8/4, 2/1
  always_comb begin
    logic [nrmb_pkg::N_W-1:0] w1, w0;
    logic [nrmb_pkg::NORM_W-1:0] x;
    logic [nrmb_pkg::N_W-1:0] l;
    unique case (nstep_r)
      2'd0:    begin w1 = 6'd32; w0 = 6'd16; end
      2'd1:    begin w1 = 6'd8;  w0 = 6'd4;  end
      2'd2:    begin w1 = 6'd2;  w0 = 6'd1;  end
      default: begin w1 = 6'd0;  w0 = 6'd0;  end
    endcase
    x = norm_r;
    l = lz_r;
    if ((x & ~({nrmb_pkg::NORM_W{1'b1}} >> w1)) == '0) begin
      x = x << w1;
      l = l + w1;
    end
    if ((x & ~({nrmb_pkg::NORM_W{1'b1}} >> w0)) == '0) begin
      x = x << w0;
      l = l + w0;
    end
    norm_nxt = x;
    lz_nxt   = l;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nrmb_pkg::F_IDLE;
      hold_full_r <= 1'b0;
      mode_r      <= 1'b0;
      nstep_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) mode_r <= cfg_wdata;
      if (in_valid && !in_stall) hold_full_r <= 1'b1;
      else if (take)             hold_full_r <= 1'b0;
      if (state_r == nrmb_pkg::F_TOT)       nstep_r <= '0;
      else if (state_r == nrmb_pkg::F_NORM) nstep_r <= nstep_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) hold_r <= in_item;
    if (take) begin
      freq_r <= {hold_r.freq_t, hold_r.freq_g, hold_r.freq_c, hold_r.freq_a};
      if (mode_r) begin
        // HKY: kappa on both transitions, unit transversions
        rate_r <= {nrmb_pkg::ONE_Q16, hold_r.rate_ag, nrmb_pkg::ONE_Q16,
                   nrmb_pkg::ONE_Q16, hold_r.rate_ag, nrmb_pkg::ONE_Q16};
      end else begin
        rate_r <= {hold_r.rate_gt, hold_r.rate_ct, hold_r.rate_cg,
                   hold_r.rate_at, hold_r.rate_ag, hold_r.rate_ac};
      end
    end
    unique case (state_r)
      nrmb_pkg::F_MUL: begin
        e_r[1]  <= ext_e(mul_rf(rate_r[0], freq_r[1]));
        e_r[4]  <= ext_e(mul_rf(rate_r[0], freq_r[0]));
        e_r[2]  <= ext_e(mul_rf(rate_r[1], freq_r[2]));
        e_r[8]  <= ext_e(mul_rf(rate_r[1], freq_r[0]));
        e_r[3]  <= ext_e(mul_rf(rate_r[2], freq_r[3]));
        e_r[12] <= ext_e(mul_rf(rate_r[2], freq_r[0]));
        e_r[6]  <= ext_e(mul_rf(rate_r[3], freq_r[2]));
        e_r[9]  <= ext_e(mul_rf(rate_r[3], freq_r[1]));
        e_r[7]  <= ext_e(mul_rf(rate_r[4], freq_r[3]));
        e_r[13] <= ext_e(mul_rf(rate_r[4], freq_r[1]));
        e_r[11] <= ext_e(mul_rf(rate_r[5], freq_r[3]));
        e_r[14] <= ext_e(mul_rf(rate_r[5], freq_r[2]));
      end
      nrmb_pkg::F_SUM: begin
        e_r[0]  <= e_r[1]  + e_r[2]  + e_r[3];
        e_r[5]  <= e_r[4]  + e_r[6]  + e_r[7];
        e_r[10] <= e_r[8]  + e_r[9]  + e_r[11];
        e_r[15] <= e_r[12] + e_r[13] + e_r[14];
      end
      nrmb_pkg::F_TMUL: begin
        for (int i = 0; i < 4; i++) tp_r[i] <= mul_ef(e_r[i*5], freq_r[i]);
      end
      nrmb_pkg::F_TOT: begin
        norm_r  <= {{(nrmb_pkg::NORM_W-nrmb_pkg::TOT_W){1'b0}}, tot_sum};
        lz_r    <= '0;
        degen_r <= (tot_sum == '0);
      end
      nrmb_pkg::F_NORM: begin
        norm_r <= norm_nxt;
        lz_r   <= lz_nxt;
      end
      default: ;
    endcase
  end

  assign q_data.e     = e_r;
  assign q_data.recip = degen_r ? '0 : div_rsp.q;
  assign q_data.n     = nrmb_pkg::N_W'(7'd64 - {1'b0, lz_r});
  assign q_data.degen = degen_r;

endmodule

// ===== rtl/nrmb_queue.sv =====
// Two-deep queue of finished matrices between front and back end.
// Depends on nrmb_pkg.
module nrmb_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nrmb_pkg::q_entry_t wdata,
  input  logic               pop,
  output nrmb_pkg::q_entry_t rdata,
  output nrmb_pkg::q_stat_t  stat
);

  nrmb_pkg::q_entry_t mem_r [nrmb_pkg::QDEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  assign rdata          = mem_r[rd_ptr_r];
  assign stat.full      = (cnt_r == 2'(nrmb_pkg::QDEPTH));
  assign stat.not_empty = (cnt_r != '0);

endmodule

// ===== rtl/nrmb_back.sv =====
// Back end: scales the 16 queue-head entries, one a cycle unless stalled,
// and saturates them into the output register. Depends on nrmb_pkg.
module nrmb_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  nrmb_pkg::q_entry_t       hd,
  input  nrmb_pkg::q_stat_t        q_stat,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_row_index,
  output logic [1:0]               out_col_index,
  output logic signed [nrmb_pkg::VAL_W-1:0] out_entry_value,
  output logic                     out_last_entry,
  output logic                     out_degenerate
);

  function automatic logic [nrmb_pkg::PP_W-1:0] mul_h(
    input logic [nrmb_pkg::HALF_W-1:0] a,
    input logic [nrmb_pkg::Q_W-1:0]    b
  );
    logic [nrmb_pkg::PP_W-1:0] aa, bb;
    aa = {{(nrmb_pkg::PP_W-nrmb_pkg::HALF_W){1'b0}}, a};
    bb = {{(nrmb_pkg::PP_W-nrmb_pkg::Q_W){1'b0}}, b};
    return aa * bb;
  endfunction

  logic                          en, issue;
  logic [3:0]                    k_r;
  logic [nrmb_pkg::E_W-1:0]      sel;

  logic                          v1_r, v2_r, ov_r;
  logic [3:0]                    k1_r, k2_r;
  logic [nrmb_pkg::N_W-1:0]      n1_r, n2_r;
  logic                          dg1_r, dg2_r;
  logic [nrmb_pkg::PP_W-1:0]     pl1_r, ph1_r;
  logic [nrmb_pkg::PROD_W-1:0]   prod2_r;
  logic [nrmb_pkg::FULL_W-1:0]   sh;
  logic [nrmb_pkg::VAL_W-1:0]    val;

  // whole pipeline holds while the output word is stalled
  assign en    = !ov_r || !out_stall;
  assign issue = en && q_stat.not_empty;
  assign q_pop = issue && (k_r == 4'd15);
  assign sel   = hd.e[k_r];

  always_comb begin
    sh = {prod2_r, 9'b0} >> n2_r;
    if (dg2_r) begin
      val = '0;
    end else if (k2_r[3:2] == k2_r[1:0]) begin
      if (sh > {{(nrmb_pkg::FULL_W-nrmb_pkg::VAL_W){1'b0}}, nrmb_pkg::NEG_LIMIT})
        val = '0 - nrmb_pkg::NEG_LIMIT;
      else
        val = '0 - sh[nrmb_pkg::VAL_W-1:0];
    end else begin
      if (sh > {{(nrmb_pkg::FULL_W-nrmb_pkg::VAL_W){1'b0}}, nrmb_pkg::POS_LIMIT})
        val = nrmb_pkg::POS_LIMIT;
      else
        val = sh[nrmb_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r  <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      if (issue) k_r <= k_r + 1'b1;
      v1_r <= issue;
      v2_r <= v1_r;
      ov_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl1_r   <= mul_h(sel[nrmb_pkg::HALF_W-1:0], hd.recip);
      ph1_r   <= mul_h(sel[nrmb_pkg::E_W-1:nrmb_pkg::HALF_W], hd.recip);
      k1_r    <= k_r;
      n1_r    <= hd.n;
      dg1_r   <= hd.degen;
      prod2_r <= {ph1_r, {nrmb_pkg::HALF_W{1'b0}}}
               + {{(nrmb_pkg::PROD_W-nrmb_pkg::PP_W){1'b0}}, pl1_r};
      k2_r    <= k1_r;
      n2_r    <= n1_r;
      dg2_r   <= dg1_r;
      out_row_index   <= k2_r[3:2];
      out_col_index   <= k2_r[1:0];
      out_entry_value <= val;
      out_last_entry  <= (k2_r == 4'd15);
      out_degenerate  <= dg2_r;
    end
  end

  assign out_valid = ov_r;

endmodule

// ===== rtl/nucleotide_rate_matrix_build.sv =====
// Top level of the nucleotide rate matrix builder: front end, queue, back end.
// Depends on nrmb_pkg, nrmb_front, nrmb_queue, nrmb_back.
//
// Each input word (six Q8.16 exchange rates, four Q0.16 frequencies) yields
// sixteen output words, the normalised Q8.24 rate matrix in row-major order,
// last_entry marking the sixteenth and degenerate set on all sixteen when the
// total rate is zero. cfg_wdata selects GTR (0) or HKY (1) and the user
// must write it only while the block is idle; the block does not enforce it.
// The front end steps each word through product, row sum, total product
// and total states, a leading-zero search, a start state, a wait on the
// nine-step reciprocal and a push state; a word with zero total skips the
// search and the reciprocal. The back end issues one entry a cycle while the
// output is not stalled, 16 a matrix, through its partial-product, product
// and output registers. A two-deep queue between them and an input holding
// register let the next word be taken while a matrix is still draining.
module nucleotide_rate_matrix_build (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] in_rate_ac,
  input  logic [23:0] in_rate_ag,
  input  logic [23:0] in_rate_at,
  input  logic [23:0] in_rate_cg,
  input  logic [23:0] in_rate_ct,
  input  logic [23:0] in_rate_gt,
  input  logic [15:0] in_freq_a,
  input  logic [15:0] in_freq_c,
  input  logic [15:0] in_freq_g,
  input  logic [15:0] in_freq_t,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_row_index,
  output logic [1:0]  out_col_index,
  output logic signed [31:0] out_entry_value,
  output logic        out_last_entry,
  output logic        out_degenerate
);

  nrmb_pkg::in_item_t in_item;
  nrmb_pkg::q_entry_t q_wdata, q_rdata;
  nrmb_pkg::q_stat_t  q_stat;
  logic               q_push, q_pop;

  assign in_item.rate_ac = in_rate_ac;
  assign in_item.rate_ag = in_rate_ag;
  assign in_item.rate_at = in_rate_at;
  assign in_item.rate_cg = in_rate_cg;
  assign in_item.rate_ct = in_rate_ct;
  assign in_item.rate_gt = in_rate_gt;
  assign in_item.freq_a  = in_freq_a;
  assign in_item.freq_c  = in_freq_c;
  assign in_item.freq_g  = in_freq_g;
  assign in_item.freq_t  = in_freq_t;

  nrmb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  nrmb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  nrmb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .hd              (q_rdata),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_index   (out_row_index),
    .out_col_index   (out_col_index),
    .out_entry_value (out_entry_value),
    .out_last_entry  (out_last_entry),
    .out_degenerate  (out_degenerate)
  );

endmodule

// ===== rtl/nrmb_checker.sv =====
// Port-level checks for the nucleotide rate matrix builder, bound to the top.
// Depends on nucleotide_rate_matrix_build's ports only.
module nrmb_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_row_index,
  input logic [1:0]        out_col_index,
  input logic signed [31:0] out_entry_value,
  input logic              out_last_entry,
  input logic              out_degenerate
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_value))
    else $error("stalled output word changed");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_entry |-> out_row_index == 2'd3 && out_col_index == 2'd3)
    else $error("last_entry off the final position");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_entry_value == 32'sd0)
    else $error("degenerate matrix with nonzero entry");

  a_offdiag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_index != out_col_index |-> !out_entry_value[31])
    else $error("negative off-diagonal entry");

  a_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_index == out_col_index
      |-> out_entry_value[31] || out_entry_value == 32'sd0)
    else $error("positive diagonal entry");

endmodule

bind nucleotide_rate_matrix_build nrmb_checker u_nrmb_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for nucleotide_rate_matrix_build.
// Predicts each normalised 4x4 rate matrix in GTR and HKY modes and checks
// all sixteen entries per word; depends on nrmb_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
    logic        last;
    logic        degen;
  } matrix_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [23:0] in_rate_ac = '0, in_rate_ag = '0, in_rate_at = '0;
  logic [23:0] in_rate_cg = '0, in_rate_ct = '0, in_rate_gt = '0;
  logic [15:0] in_freq_a = '0, in_freq_c = '0, in_freq_g = '0, in_freq_t = '0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_row_index, out_col_index;
  logic signed [31:0] out_entry_value;
  logic out_last_entry, out_degenerate;

  logic mode_hky = 1'b0;
  matrix_entry_t pending_entries[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 24;
  localparam int CYCLE_LIMIT = 400000;

  nucleotide_rate_matrix_build dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_rate_ac(in_rate_ac), .in_rate_ag(in_rate_ag), .in_rate_at(in_rate_at),
    .in_rate_cg(in_rate_cg), .in_rate_ct(in_rate_ct), .in_rate_gt(in_rate_gt),
    .in_freq_a(in_freq_a), .in_freq_c(in_freq_c), .in_freq_g(in_freq_g),
    .in_freq_t(in_freq_t),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_row_index(out_row_index), .out_col_index(out_col_index),
    .out_entry_value(out_entry_value), .out_last_entry(out_last_entry),
    .out_degenerate(out_degenerate)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** nucleotide_rate_matrix_build: FAILED **");
      $finish;
    end
  end

  // floor(mag * 2^9 * recip / 2^n), clipped at limit
  function automatic logic [63:0] scale_entry(logic [63:0] mag, logic [63:0] recip,
                                             int n, logic [63:0] limit);
    logic [127:0] prod;
    logic [127:0] res;
    prod = {64'd0, mag << 9} * {64'd0, recip};
    res  = prod >> n;
    return (res > {64'd0, limit}) ? limit : res[63:0];
  endfunction

  task automatic predict_matrix(nrmb_pkg::in_item_t w);
    logic [63:0] rate[6], freq[4], e[4][4], rsum, total, m, recip, t, mag;
    logic [31:0] v;
    int n, k;
    matrix_entry_t ent;
    rate = '{w.rate_ac, w.rate_ag, w.rate_at, w.rate_cg, w.rate_ct, w.rate_gt};
    freq = '{w.freq_a, w.freq_c, w.freq_g, w.freq_t};
    if (mode_hky)
      rate = '{nrmb_pkg::ONE_Q16, w.rate_ag, nrmb_pkg::ONE_Q16,
               nrmb_pkg::ONE_Q16, w.rate_ag, nrmb_pkg::ONE_Q16};
    k = 0;
    for (int i = 0; i < 4; i++)
      for (int j = i + 1; j < 4; j++) begin
        e[i][j] = rate[k] * freq[j];
        e[j][i] = rate[k] * freq[i];
        k++;
      end
    total = '0;
    for (int i = 0; i < 4; i++) begin
      rsum = '0;
      for (int j = 0; j < 4; j++)
        if (i != j) rsum += e[i][j];
      e[i][i] = rsum;
      total += rsum * freq[i];
    end
    n = 0; recip = '0;
    if (total != 0) begin
      t = total;
      while (t != 0) begin n++; t >>= 1; end
      m = (n > 32) ? (total >> (n - 32)) : (total << (32 - n));
      recip = (64'd1 << 63) / m;
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        v = '0;
        if (total != 0) begin
          if (i == j) begin
            mag = scale_entry(e[i][j], recip, n, 64'h80000000);
            v = 32'(64'h100000000 - mag);
          end else
            v = 32'(scale_entry(e[i][j], recip, n, 64'h7FFFFFFF));
        end
        ent.row = 2'(i); ent.col = 2'(j); ent.value = v;
        ent.last = (i == 3 && j == 3); ent.degen = (total == 0);
        pending_entries.push_back(ent);
      end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    matrix_entry_t x;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_entries.size() == 0) report("unexpected word", 0, 0);
      else begin
        x = pending_entries.pop_front();
        if (out_row_index != x.row) report("row_index", out_row_index, x.row);
        if (out_col_index != x.col) report("col_index", out_col_index, x.col);
        if (out_entry_value != x.value) report("entry_value", out_entry_value, x.value);
        if (out_last_entry != x.last) report("last_entry", out_last_entry, x.last);
        if (out_degenerate != x.degen) report("degenerate", out_degenerate, x.degen);
      end
    end
  end

  always @(posedge clk)
    out_stall <= ($urandom_range(99) < idle_pct);

  // valid stays up after a word is taken so the next can follow at once;
  // it drops on an idle cycle or in drain
  task automatic send_word(nrmb_pkg::in_item_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_rate_ac, in_rate_ag, in_rate_at, in_rate_cg, in_rate_ct, in_rate_gt,
     in_freq_a, in_freq_c, in_freq_g, in_freq_t} <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_matrix(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_mode(logic hky);
    drain();
    cfg_we <= 1'b1; cfg_wdata <= hky;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_hky = hky;
  endtask

  function automatic nrmb_pkg::in_item_t rand_word(bit wild);
    nrmb_pkg::in_item_t w;
    logic [223:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = bits[207:0];
    if (!wild) begin
      // plausible rates up to 4.0 (8.0 for AG and CT) and frequencies up to 0.4375
      w.rate_ac = 24'($urandom_range(24'h40000));
      w.rate_ag = 24'($urandom_range(24'h80000));
      w.rate_at = 24'($urandom_range(24'h40000));
      w.rate_cg = 24'($urandom_range(24'h40000));
      w.rate_ct = 24'($urandom_range(24'h80000));
      w.rate_gt = 24'($urandom_range(24'h40000));
      w.freq_a = 16'($urandom_range(16'h7000)); w.freq_c = 16'($urandom_range(16'h7000));
      w.freq_g = 16'($urandom_range(16'h7000)); w.freq_t = 16'($urandom_range(16'h7000));
    end else if ($urandom_range(9) == 0) w.freq_c = '0;
    return w;
  endfunction

  task automatic test_directed(logic hky);
    nrmb_pkg::in_item_t w;
    set_mode(hky);
    send_word('0);                      // zero total, degenerate
    w = '1; send_word(w);               // all extremes
    w = '0; w.freq_a = 16'h4000; send_word(w);  // single base, still degenerate
    w = '0; w.rate_ag = 24'h020000; w.freq_a = 16'h4000; w.freq_g = 16'h4000;
    send_word(w);
    w = {{6{24'h010000}}, {4{16'h4000}}}; send_word(w);  // uniform
    w = {{6{24'hFFFFFF}}, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF}; send_word(w);
    w = {{6{24'h000001}}, {4{16'h0001}}}; send_word(w);  // tiny total
    w = {24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'h000001,
         16'hFFFF, 16'h0001, 16'h8000, 16'h0100}; send_word(w);
  endtask

  task automatic test_random(logic hky, int count);
    set_mode(hky);
    for (int i = 0; i < count; i++) begin
      send_word(rand_word($urandom_range(2) == 0));
      if (i == count / 2) drain();        // sender holds off until empty
    end
  endtask

  task automatic test_no_idle(int count);
    idle_pct = 0;
    for (int i = 0; i < count; i++) send_word(rand_word($urandom_range(1) == 1));
    idle_pct = 24;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed(1'b0);
    test_directed(1'b1);
    test_random(1'b0, 150);
    test_random(1'b1, 120);
    test_no_idle(60);
    test_random(1'b0, 80);
    drain();
    if (errors == 0) $display("** nucleotide_rate_matrix_build: PASSED **");
    else $display("** nucleotide_rate_matrix_build: FAILED **");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/nrmb_pkg.sv
rtl/nrmb_recip.sv
rtl/nrmb_front.sv
rtl/nrmb_queue.sv
rtl/nrmb_back.sv
rtl/nucleotide_rate_matrix_build.sv
rtl/nrmb_checker.sv
dv/tb_top.sv
